// File: design/hdtc_pkg.sv
// shared types, constants and crc function for the humidity/temperature frame checker
package hdtc_pkg;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	// byte positions inside one six-byte response
	localparam logic [2:0] POS_TEMP_HI  = 3'd0;
	localparam logic [2:0] POS_TEMP_LO  = 3'd1;
	localparam logic [2:0] POS_TEMP_CRC = 3'd2;
	localparam logic [2:0] POS_HUM_HI   = 3'd3;
	localparam logic [2:0] POS_HUM_LO   = 3'd4;
	localparam logic [2:0] POS_HUM_CRC  = 3'd5;

	// conversion scale factors, values in hundredths
	localparam int TEMP_SPAN   = 17500;
	localparam int TEMP_OFFSET = 4500;
	localparam int HUM_SPAN    = 10000;
	localparam int RAW_FULL    = 65535;
	localparam int TEMP_MAX    = 13000;

	localparam int OUT_DATA_W = 64;

	// frame result handed from the frame tracker to the converter
	typedef struct packed {
		logic [15:0] temp_word;
		logic [15:0] hum_word;
		logic        temperature_crc_ok;
		logic        humidity_crc_ok;
	} frame_res_t;

	// crc-8, msb first, one byte
	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: design/humidity_temp_frame_checker_top.sv
// an accepted byte passes the input register, the frame result register and the output register before m_tvalid
// throughput: one byte per cycle, the whole pipeline advances whenever the output is free
// a result appears once per six-byte frame, after the humidity crc byte
// s_tready follows m_tready combinationally when the output register is full
// reset (arst_n low) clears byte position, crc to 0xff, held words to zero, all valid bits
module humidity_temp_frame_checker_top (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] frame_start
	// result side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [15:0] temp_word, [31:16] hum_word,
	                               // [46:32] temperature_centi, [60:47] humidity_centi,
	                               // [61] temperature_crc_ok, [62] humidity_crc_ok, [63] status
);

	logic                 en;
	logic                 vld_s1;
	logic [7:0]           byte_s1;
	logic                 start_s1;
	logic                 res_vld_s2;
	hdtc_pkg::frame_res_t res_s2;
	logic signed [14:0]   t_centi;
	logic [13:0]          h_centi;
	logic                 out_vld_q;
	logic [hdtc_pkg::OUT_DATA_W-1:0] out_data_q;

	// whole pipeline moves together whenever the output register can take a result
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// crc check and held-word tracking, registers its frame result
	hdtc_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vld_s1     (vld_s1),
		.byte_s1    (byte_s1),
		.start_s1   (start_s1),
		.res_vld_s2 (res_vld_s2),
		.res_s2     (res_s2)
	);

	// scaling to hundredths
	hdtc_conv u_conv (
		.res               (res_s2),
		.temperature_centi (t_centi),
		.humidity_centi    (h_centi)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= res_vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {
				!(res_s2.temperature_crc_ok && res_s2.humidity_crc_ok),
				res_s2.humidity_crc_ok,
				res_s2.temperature_crc_ok,
				h_centi,
				t_centi,
				res_s2.hum_word,
				res_s2.temp_word
			};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// a new frame result can only come from a byte sitting in the input register
	a_res_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_vld_s2) |-> $past(vld_s1))
		else $error("frame result without an input byte");

	// status is the inverse of both crc flags
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[63] == !(m_tdata[61] && m_tdata[62])))
		else $error("status disagrees with crc flags");

	// humidity never exceeds 100.00 percent
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[60:47] <= 14'(hdtc_pkg::HUM_SPAN)))
		else $error("humidity out of range");

	// temperature stays within -45.00 .. 130.00
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((signed'(m_tdata[46:32]) >= -15'sd4500)
			&& (signed'(m_tdata[46:32]) <= 15'(hdtc_pkg::TEMP_MAX))))
		else $error("temperature out of range");

endmodule

// File: design/hdtc_frame.sv
// frame tracker: byte position, running crc, held words, result stage register
module hdtc_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_s1,
	input  logic [7:0]           byte_s1,
	input  logic                 start_s1,
	output logic                 res_vld_s2,
	output hdtc_pkg::frame_res_t res_s2
);

	logic [2:0]  pos_q, pos_d, pos_eff;
	logic [7:0]  crc_q, crc_d, crc_cur, crc_fed;
	logic [7:0]  hi_q, hi_d, lo_q, lo_d;
	logic        t_pass_q, t_pass_d;
	logic [15:0] temp_q, temp_d, hum_q, hum_d;
	logic        restart, crc_ok, fire, h_ok;

	assign restart = start_s1 || (pos_q > hdtc_pkg::POS_HUM_CRC);
	assign pos_eff = restart ? hdtc_pkg::POS_TEMP_HI : pos_q;
	assign crc_cur = restart ? hdtc_pkg::CRC_INIT : crc_q;
	assign crc_fed = hdtc_pkg::crc8_feed(crc_cur, byte_s1);
	assign crc_ok  = (byte_s1 == crc_cur);

	always_comb begin
		pos_d    = pos_q;
		crc_d    = crc_q;
		hi_d     = hi_q;
		lo_d     = lo_q;
		t_pass_d = t_pass_q;
		temp_d   = temp_q;
		hum_d    = hum_q;
		fire     = 1'b0;
		h_ok     = 1'b0;
		case (pos_eff)
			hdtc_pkg::POS_TEMP_HI, hdtc_pkg::POS_HUM_HI: begin
				crc_d = crc_fed;
				hi_d  = byte_s1;
				pos_d = 3'(pos_eff + 3'd1);
			end
			hdtc_pkg::POS_TEMP_LO, hdtc_pkg::POS_HUM_LO: begin
				crc_d = crc_fed;
				lo_d  = byte_s1;
				pos_d = 3'(pos_eff + 3'd1);
			end
			hdtc_pkg::POS_TEMP_CRC: begin
				t_pass_d = crc_ok;
				if (crc_ok) begin
					temp_d = {hi_q, lo_q};
				end
				crc_d = hdtc_pkg::CRC_INIT;
				pos_d = hdtc_pkg::POS_HUM_HI;
			end
			default: begin
				// humidity crc byte closes the frame
				if (crc_ok) begin
					hum_d = {hi_q, lo_q};
				end
				crc_d = hdtc_pkg::CRC_INIT;
				pos_d = hdtc_pkg::POS_TEMP_HI;
				fire  = 1'b1;
				h_ok  = crc_ok;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= hdtc_pkg::POS_TEMP_HI;
			crc_q    <= hdtc_pkg::CRC_INIT;
			hi_q     <= '0;
			lo_q     <= '0;
			t_pass_q <= 1'b0;
			temp_q   <= '0;
			hum_q    <= '0;
		end else if (en && vld_s1) begin
			pos_q    <= pos_d;
			crc_q    <= crc_d;
			hi_q     <= hi_d;
			lo_q     <= lo_d;
			t_pass_q <= t_pass_d;
			temp_q   <= temp_d;
			hum_q    <= hum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s2 <= 1'b0;
		end else if (en) begin
			res_vld_s2 <= vld_s1 && fire;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2.temp_word          <= temp_d;
			res_s2.hum_word           <= hum_d;
			res_s2.temperature_crc_ok <= t_pass_q;
			res_s2.humidity_crc_ok    <= h_ok;
		end
	end

endmodule

// File: design/hdtc_conv.sv
// converter: raw words to hundredths via multiply and divide by 65535
module hdtc_conv (
	input  hdtc_pkg::frame_res_t res,
	output logic signed [14:0]   temperature_centi,
	output logic [13:0]          humidity_centi
);

	logic [30:0] t_prod;
	logic [29:0] h_prod;
	logic [14:0] t_quot, h_quot;

	// floor(n / 65535) as n>>16 plus one correction step
	function automatic logic [14:0] div_full(input logic [30:0] n);
		logic [14:0] q0;
		logic [16:0] r0;
		q0 = n[30:16];
		r0 = {1'b0, n[15:0]} + {2'b0, q0};
		return 15'(q0 + 15'(r0 >= 17'(hdtc_pkg::RAW_FULL)));
	endfunction

	assign t_prod = 31'(hdtc_pkg::TEMP_SPAN) * {15'b0, res.temp_word};
	assign h_prod = 30'(hdtc_pkg::HUM_SPAN) * {14'b0, res.hum_word};
	assign t_quot = div_full(t_prod);
	assign h_quot = div_full({1'b0, h_prod});

	assign temperature_centi = 15'(signed'({1'b0, t_quot}) - 16'(hdtc_pkg::TEMP_OFFSET));
	assign humidity_centi    = h_quot[13:0];

endmodule
